// ===== hw/rtl/fully_associative_fifo_cache_assert.svh =====
// Assertion macros used by the cache RTL.
`ifndef FULLY_ASSOCIATIVE_FIFO_CACHE_ASSERT_SVH
`define FULLY_ASSOCIATIVE_FIFO_CACHE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define FAC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cache assertion failed");

// Next-cycle implication, disabled while reset is high.
`define FAC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cache assertion failed");

`endif

// ===== hw/rtl/fac_pkg.sv =====
// Package with the types and constants of the fully associative cache.
package fac_pkg;

  localparam int DEFAULT_LINES  = 16;
  localparam int WORDS_PER_LINE = 16;
  localparam int TAG_W          = 12;
  localparam int OFF_W          = 4;
  localparam int ADDR_W         = 16;
  localparam int WORD_W         = 32;
  localparam int STATUS_W       = 2;
  localparam int SLOT_W         = 4;

  localparam logic OP_READ = 1'b0;
  localparam logic OP_FILL = 1'b1;

  localparam logic [STATUS_W-1:0] ST_HIT  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DONE = 2'd2;

  localparam logic [OFF_W-1:0] LAST_WORD = OFF_W'(WORDS_PER_LINE - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_DATA_RD,
    S_EMIT
  } state_t;

endpackage

// ===== hw/rtl/fully_associative_fifo_cache.sv =====
// Fully associative read cache with FIFO replacement, top level.
//
// Fully associative read cache of LINES lines of sixteen 32-bit words. An
// item with opcode read looks up its 16-bit address (tag in bits 15..4,
// word offset in bits 3..0). One tag comparator walks the tag memory one
// line per cycle. An accepted read holds the block through the search,
// then decide, data read (on a hit only) and emit states. A hit returns
// status 0 with the word. A miss allocates a line (empty lines first, in
// order, then the oldest line in FIFO order), returns status 1 with the tag
// to fetch and the line index, and the block then expects sixteen items
// with opcode fill carrying the line's words in order. Fill items before
// the last keep the block idle; after it the requested word is read
// back from the data memory and returned with status 2. Reads that arrive
// while a fill is pending, and fill items with no fill pending, are dropped
// without a result. The line index on line_slot is the low four bits of the
// index. There is no clearing pass after reset; line valid bits live in
// flip-flops. A finished result waits in the output register while the
// next item is already accepted.
module fully_associative_fifo_cache #(
  parameter int LINES = fac_pkg::DEFAULT_LINES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           opcode,
  input  logic [fac_pkg::ADDR_W-1:0]     address,
  input  logic [fac_pkg::WORD_W-1:0]     fill_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [fac_pkg::STATUS_W-1:0]   status,
  output logic [fac_pkg::WORD_W-1:0]     read_data,
  output logic [fac_pkg::TAG_W-1:0]      fetch_tag,
  output logic [fac_pkg::SLOT_W-1:0]     line_slot
);

  `include "fully_associative_fifo_cache_assert.svh"

  localparam int IDX_W  = $clog2(LINES);
  localparam int LVL_W  = $clog2(LINES + 1);
  localparam int MEM_W  = IDX_W + fac_pkg::OFF_W;
  localparam int DEPTH  = LINES * fac_pkg::WORDS_PER_LINE;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINES - 1);
  localparam logic [LVL_W-1:0] FULL_LVL = LVL_W'(LINES);

  fac_pkg::state_t state, state_next;

  // Memories.
  logic [fac_pkg::TAG_W-1:0]  tags  [LINES];
  logic [fac_pkg::WORD_W-1:0] words [DEPTH];

  // Line bookkeeping.
  logic [LINES-1:0]          line_valid;
  logic [LVL_W-1:0]          fill_level;
  logic [IDX_W-1:0]          oldest_line;
  logic                      pending_fill;
  logic [fac_pkg::OFF_W-1:0] fill_index;
  logic [IDX_W-1:0]          pending_slot;
  logic [fac_pkg::OFF_W-1:0] pending_offset;
  logic [fac_pkg::TAG_W-1:0] pending_tag;

  // Search datapath.
  logic [fac_pkg::TAG_W-1:0] req_tag;
  logic [fac_pkg::OFF_W-1:0] req_off;
  logic [IDX_W-1:0]          idx;
  logic [IDX_W-1:0]          probe_idx;
  logic                      probe_live;
  logic [fac_pkg::TAG_W-1:0] tag_q;
  logic                      valid_q;
  logic                      hit;
  logic [IDX_W-1:0]          hit_slot;

  // Result staging.
  logic [fac_pkg::STATUS_W-1:0] res_status;
  logic [IDX_W-1:0]             res_slot;
  logic [fac_pkg::TAG_W-1:0]    res_tag;
  logic [MEM_W-1:0]             rd_addr;
  logic [fac_pkg::WORD_W-1:0]   data_q;

  // Control strobes.
  logic             accept;
  logic             take_read;
  logic             take_fill;
  logic             fill_last;
  logic             match_now;
  logic             hit_now;
  logic [IDX_W-1:0] slot_now;
  logic [IDX_W-1:0] alloc_slot;
  logic             do_alloc;
  logic             out_free;
  logic             emit;

  assign in_stall  = (state != fac_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign take_read = accept && (opcode == fac_pkg::OP_READ) && !pending_fill;
  assign take_fill = accept && (opcode == fac_pkg::OP_FILL) && pending_fill;
  assign fill_last = (fill_index == fac_pkg::LAST_WORD);

  // The shared comparator looks at the tag read out in the previous cycle.
  assign match_now = probe_live && valid_q && (tag_q == req_tag);
  assign hit_now   = hit || match_now;
  assign slot_now  = match_now ? probe_idx : hit_slot;
  assign alloc_slot = (fill_level < FULL_LVL) ? fill_level[IDX_W-1:0] : oldest_line;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fac_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    do_alloc   = 1'b0;
    emit       = 1'b0;
    case (state)
      fac_pkg::S_IDLE: begin
        if (take_read) begin
          state_next = fac_pkg::S_SEARCH;
        end else if (take_fill && fill_last) begin
          state_next = fac_pkg::S_DATA_RD;
        end
      end
      fac_pkg::S_SEARCH: begin
        if (idx == LAST_IDX) begin
          state_next = fac_pkg::S_DECIDE;
        end
      end
      fac_pkg::S_DECIDE: begin
        if (hit_now) begin
          state_next = fac_pkg::S_DATA_RD;
        end else begin
          do_alloc   = 1'b1;
          state_next = fac_pkg::S_EMIT;
        end
      end
      fac_pkg::S_DATA_RD: begin
        state_next = fac_pkg::S_EMIT;
      end
      fac_pkg::S_EMIT: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = fac_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fac_pkg::S_IDLE;
      end
    endcase
  end

  // Tag memory: written on allocation, read one line per cycle while searching.
  always_ff @(posedge clk) begin
    if (do_alloc) begin
      tags[alloc_slot] <= req_tag;
    end
    tag_q <= tags[idx];
  end

  // Data memory: written by fill items, read once per hit or finished fill.
  always_ff @(posedge clk) begin
    if (take_fill) begin
      words[{pending_slot, fill_index}] <= fill_word;
    end
    data_q <= words[rd_addr];
  end

  // Bookkeeping that reset must clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid   <= '0;
      fill_level   <= '0;
      oldest_line  <= '0;
      pending_fill <= 1'b0;
      fill_index   <= '0;
      pending_slot <= '0;
      probe_live   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      probe_live <= (state == fac_pkg::S_SEARCH);
      if (do_alloc) begin
        line_valid[alloc_slot] <= 1'b1;
        pending_fill <= 1'b1;
        fill_index   <= '0;
        pending_slot <= alloc_slot;
        if (fill_level < FULL_LVL) begin
          fill_level <= fill_level + LVL_W'(1);
        end else if (oldest_line == LAST_IDX) begin
          oldest_line <= '0;
        end else begin
          oldest_line <= oldest_line + IDX_W'(1);
        end
      end
      if (take_fill) begin
        if (fill_last) begin
          pending_fill <= 1'b0;
          fill_index   <= '0;
        end else begin
          fill_index <= fill_index + fac_pkg::OFF_W'(1);
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    valid_q   <= line_valid[idx];
    probe_idx <= idx;
    if (take_read) begin
      req_tag <= address[fac_pkg::ADDR_W-1:fac_pkg::OFF_W];
      req_off <= address[fac_pkg::OFF_W-1:0];
      idx     <= '0;
      hit     <= 1'b0;
    end
    if (state == fac_pkg::S_SEARCH) begin
      if (idx != LAST_IDX) begin
        idx <= idx + IDX_W'(1);
      end
      if (match_now) begin
        hit      <= 1'b1;
        hit_slot <= probe_idx;
      end
    end
    if (state == fac_pkg::S_DECIDE) begin
      res_tag <= req_tag;
      if (hit_now) begin
        res_status <= fac_pkg::ST_HIT;
        res_slot   <= slot_now;
        rd_addr    <= {slot_now, req_off};
      end else begin
        res_status <= fac_pkg::ST_MISS;
        res_slot   <= alloc_slot;
      end
    end
    if (do_alloc) begin
      pending_offset <= req_off;
      pending_tag    <= req_tag;
    end
    if (take_fill && fill_last) begin
      res_status <= fac_pkg::ST_DONE;
      res_tag    <= pending_tag;
      res_slot   <= pending_slot;
      rd_addr    <= {pending_slot, pending_offset};
    end
    if (emit) begin
      status    <= res_status;
      read_data <= (res_status == fac_pkg::ST_MISS) ? '0 : data_q;
      fetch_tag <= res_tag;
      line_slot <= fac_pkg::SLOT_W'(res_slot);
    end
  end

  // The allocation count never passes the number of lines.
  `FAC_ASSERT_NOW(a_level_bound, clk, rst, 1'b1, fill_level <= FULL_LVL)

  // A miss result always carries a zero data word.
  `FAC_ASSERT_NOW(a_miss_zero, clk, rst,
                  out_valid && (status == fac_pkg::ST_MISS), read_data == '0)

  // The last fill word of a line starts the read-back of the requested word.
  `FAC_ASSERT_NEXT(a_last_fill, clk, rst, take_fill && fill_last,
                   (state == fac_pkg::S_DATA_RD) && !pending_fill)

endmodule
